FILE: design/assert_macros.svh
// assertion helpers used by the report builder design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/hskrb_pkg.sv
package hskrb_pkg;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} hskrb_state_t;

	// modifier codes 0xe0..0xe7 share this upper code part
	localparam logic [4:0] MOD_PREFIX = 5'b11100;

	// boot report always carries six key slots
	localparam int REPORT_SLOTS = 6;

	typedef logic [7:0] key_code_t;

endpackage

FILE: design/hskrb_ram.sv
module hskrb_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/hid_six_key_report_builder_unit.sv
// usb hid boot keyboard report builder, six key rollover
//
// input channel (in_valid / in_ready) carries one key event word: key_code and
// pressed (1 press, 0 release). output channel (out_valid / out_ready) returns
// one report word per event: send_report, modifier_byte, slot_0..slot_5 and
// slots_used. send_report is high when the event changed the report.
//
// an accepted word and its pressed-map bit are registered in the lookup stage;
// the report registers load when that word commits. the pressed map lives in a
// single-port-read ram with a registered read, and one event is in flight at a
// time: a new word is taken only once the last one has committed.
//
// reset: slots, modifiers and count clear at once; the pressed map is then
// swept to zero, one code per cycle, while in_ready stays low.
//
// receiver stall: a report word holds on the outputs until taken. one more
// event may be accepted meanwhile; it waits in the lookup stage and commits
// only when the output word is taken, so the report never changes under a
// waiting word.
`include "assert_macros.svh"

module hid_six_key_report_builder_unit #(
	parameter int SLOT_COUNT = 6,
	parameter int CODE_SPACE = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hskrb_pkg::key_code_t   key_code,
	input  logic                   pressed,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   send_report,
	output logic [7:0]             modifier_byte,
	output logic [7:0]             slot_0,
	output logic [7:0]             slot_1,
	output logic [7:0]             slot_2,
	output logic [7:0]             slot_3,
	output logic [7:0]             slot_4,
	output logic [7:0]             slot_5,
	output logic [2:0]             slots_used
);

	import hskrb_pkg::*;

	localparam int AW = $clog2(CODE_SPACE);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	// sequencer
	hskrb_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic          clr_done;
	logic          accept;
	logic          commit;

	// event held in the lookup stage
	key_code_t     key_s1;
	logic          press_s1;
	logic          code_ok_s1;

	// report state
	logic [7:0]    mod_q;
	key_code_t     slot_q [SLOT_COUNT];
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic          send_q;

	// pressed map ram
	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic          map_wdata;
	logic          map_hit;

	// update logic
	logic          is_mod;
	logic [7:0]    mod_bit;
	logic          found;
	logic [CW-1:0] match_idx;
	logic [CW-1:0] last_idx;
	logic          changed;
	logic [7:0]    mod_d;
	key_code_t     slot_d [SLOT_COUNT];
	logic [CW-1:0] count_d;
	key_code_t     rpt [REPORT_SLOTS];

	assign accept   = in_valid && in_ready;
	assign clr_done = (clr_q == AW'(CODE_SPACE - 1));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// commit only once the output word is free or being taken
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// event capture, code zero and codes beyond the map are no-ops
	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1     <= key_code;
			press_s1   <= pressed;
			code_ok_s1 <= (key_code != '0) && ({1'b0, key_code} < 9'(CODE_SPACE));
		end
	end

	// map write: sweep during clear, else the new pressed state on commit
	always_comb begin
		if (state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
			map_wdata = 1'b0;
		end else begin
			map_we    = commit && code_ok_s1;
			map_waddr = key_s1[AW-1:0];
			map_wdata = press_s1;
		end
	end

	hskrb_ram #(
		.WIDTH(1),
		.DEPTH(CODE_SPACE)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (accept),
		.raddr(key_code[AW-1:0]),
		.rdata(map_hit)
	);

	assign is_mod   = (key_s1[7:3] == MOD_PREFIX);
	assign mod_bit  = 8'(1) << key_s1[2:0];
	assign last_idx = count_q - CW'(1);

	// first slot holding the released code
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!found && (CW'(i) < count_q) && (slot_q[i] == key_s1)) begin
				found     = 1'b1;
				match_idx = CW'(i);
			end
		end
	end

	// next report state
	always_comb begin
		changed = 1'b0;
		mod_d   = mod_q;
		count_d = count_q;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_d[i] = slot_q[i];
		end
		if (code_ok_s1) begin
			if (press_s1 && !map_hit) begin
				if (is_mod) begin
					mod_d   = mod_q | mod_bit;
					changed = 1'b1;
				end else if (count_q < CW'(SLOT_COUNT)) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (count_q == CW'(i)) begin
							slot_d[i] = key_s1;
						end
					end
					count_d = count_q + CW'(1);
					changed = 1'b1;
				end
			end else if (!press_s1 && map_hit) begin
				if (is_mod) begin
					mod_d   = mod_q & ~mod_bit;
					changed = 1'b1;
				end else if (found) begin
					// last occupied slot moves into the hole, then empties
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (last_idx == CW'(i)) begin
							slot_d[i] = '0;
						end else if (match_idx == CW'(i)) begin
							slot_d[i] = slot_q[last_idx[$clog2(SLOT_COUNT > 1 ? SLOT_COUNT : 2)-1:0]];
						end
					end
					count_d = last_idx;
					changed = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			send_q      <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			if (commit) begin
				mod_q       <= mod_d;
				count_q     <= count_d;
				send_q      <= changed;
				out_valid_q <= 1'b1;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					slot_q[i] <= slot_d[i];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// report slots, missing ones read as empty
	for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_rpt
		if (j < SLOT_COUNT) begin : g_slot
			assign rpt[j] = slot_q[j];
		end else begin : g_empty
			assign rpt[j] = '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_report   = send_q;
	assign modifier_byte = mod_q;
	assign slot_0        = rpt[0];
	assign slot_1        = rpt[1];
	assign slot_2        = rpt[2];
	assign slot_3        = rpt[3];
	assign slot_4        = rpt[4];
	assign slot_5        = rpt[5];
	assign slots_used    = 3'(count_q);

	`ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(SLOT_COUNT))
	`ASSERT_NEXT(a_commit_shows, clk, arst_n, commit, out_valid_q && (state_q == ST_IDLE))
	`ASSERT_NEXT(a_quiet_no_change, clk, arst_n, commit && !changed,
		$stable(mod_q) && $stable(count_q) && !send_q)
	`ASSERT_SAME(a_report_holds, clk, arst_n, out_valid_q && !out_ready && !commit,
		state_d != ST_CLEAR)

endmodule

FILE: tb/hid_six_key_report_builder_unit_test.sv
`timescale 1ns / 100ps

module hid_six_key_report_builder_unit_test;

	import hskrb_pkg::*;

	localparam int RANDOM_EVENTS = 1400;
	localparam int CYCLE_LIMIT   = 600000;

	// one key event word as offered to the block
	typedef struct packed {
		key_code_t code;
		logic      press;
	} key_event_t;

	// one boot report word
	typedef struct packed {
		logic                           send;
		logic [7:0]                     mods;
		logic [REPORT_SLOTS-1:0][7:0]   slots;
		logic [2:0]                     used;
	} boot_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	key_code_t   key_code = '0;
	logic        pressed = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        send_report;
	logic [7:0]  modifier_byte;
	logic [7:0]  slot_0, slot_1, slot_2, slot_3, slot_4, slot_5;
	logic [2:0]  slots_used;

	hid_six_key_report_builder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.key_code      (key_code),
		.pressed       (pressed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.send_report   (send_report),
		.modifier_byte (modifier_byte),
		.slot_0        (slot_0),
		.slot_1        (slot_1),
		.slot_2        (slot_2),
		.slot_3        (slot_3),
		.slot_4        (slot_4),
		.slot_5        (slot_5),
		.slots_used    (slots_used)
	);

	// stimulus and scoreboard storage
	key_event_t   key_events[$];     // words not yet offered
	boot_report_t owed_reports[$];   // reports predicted, not yet seen

	// predictor state, mirrors the block
	bit [255:0]   held_map;
	logic [7:0]   mod_state;
	logic [7:0]   slot_codes[REPORT_SLOTS];
	int unsigned  slot_fill;

	// generator view of which codes are down, kept apart from the predictor
	bit [255:0]   gen_held;
	int           gen_held_count;

	// run bookkeeping
	int  mismatches;
	int  events_taken;
	int  reports_seen;
	int  reports_changed;
	int  full_presses;
	int  long_holds;
	int  max_fill;
	int  cycles;
	logic in_taken = 1'b0;

	// clock, 4 ns period
	initial begin
		forever #2 clk = ~clk;
	end

	// predictor: update the mirrored state for one event and build its report
	function automatic boot_report_t apply_key_event(key_code_t code, logic press);
		boot_report_t rpt;
		logic         changed;
		logic         is_mod;
		int           i;
		changed = 1'b0;
		is_mod  = (code[7:3] == MOD_PREFIX);
		// code zero means no key at all
		if (code != '0) begin
			if (press && !held_map[code]) begin
				if (is_mod) begin
					mod_state[code[2:0]] = 1'b1;
					changed = 1'b1;
				end else if (slot_fill < REPORT_SLOTS) begin
					slot_codes[slot_fill] = code;
					slot_fill++;
					changed = 1'b1;
				end else begin
					full_presses++;
				end
				held_map[code] = 1'b1;
			end else if (!press && held_map[code]) begin
				if (is_mod) begin
					mod_state[code[2:0]] = 1'b0;
					changed = 1'b1;
				end else begin
					// last occupied slot moves into the hole
					for (i = 0; i < REPORT_SLOTS; i++) begin
						if (!changed && i < slot_fill && slot_codes[i] == code) begin
							slot_fill--;
							slot_codes[i] = slot_codes[slot_fill];
							slot_codes[slot_fill] = '0;
							changed = 1'b1;
						end
					end
				end
				held_map[code] = 1'b0;
			end
		end
		rpt.send = changed;
		rpt.mods = mod_state;
		for (i = 0; i < REPORT_SLOTS; i++)
			rpt.slots[i] = slot_codes[i];
		rpt.used = slot_fill[2:0];
		return rpt;
	endfunction

	// queue one word and track what the generator believes is held
	task automatic queue_key(key_code_t code, logic press);
		key_events.push_back('{code: code, press: press});
		if (code != '0 && gen_held[code] != press) begin
			gen_held[code] = press;
			gen_held_count += press ? 1 : -1;
		end
	endtask

	// any held code, scanning from a random start
	function automatic key_code_t pick_held();
		int start;
		int k;
		key_code_t c;
		start = $urandom_range(1, 255);
		for (k = 0; k < 255; k++) begin
			c = key_code_t'(((start - 1 + k) % 255) + 1);
			if (gen_held[c])
				return c;
		end
		return key_code_t'(0);
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// random part: mostly plausible typing, some noise
	task automatic queue_random_event();
		int r;
		key_code_t c;
		r = $urandom_range(0, 99);
		// lean toward releases once many keys are down
		if (gen_held_count > 9 && r < 40)
			r = 50;
		if (r < 10) begin
			queue_key(key_code_t'({MOD_PREFIX, 3'($urandom_range(0, 7))}), 1'b1);
		end else if (r < 40) begin
			queue_key(key_code_t'($urandom_range(1, 255)), 1'b1);
		end else if (r < 80) begin
			c = pick_held();
			if (c == '0)
				c = key_code_t'($urandom_range(1, 255));
			queue_key(c, c != '0 && !gen_held[c]);
		end else if (r < 88) begin
			// repeat press of a code already down
			c = pick_held();
			queue_key(c == '0 ? key_code_t'($urandom_range(1, 255)) : c, 1'b1);
		end else if (r < 94) begin
			// release of whatever code, often not held
			queue_key(key_code_t'($urandom_range(1, 255)), 1'b0);
		end else begin
			queue_key(key_code_t'(0), 1'($urandom_range(0, 1)));
		end
	endtask

	// driver: new word or idle at the falling edge
	always @(negedge clk) begin : drive_events
		static int gap_left = 0;
		static int calm_left = 0;
		key_event_t ev;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (key_events.size() > 0) begin
				ev = key_events.pop_front();
				in_valid <= 1'b1;
				key_code <= ev.code;
				pressed  <= ev.press;
				// occasional run of back-to-back words
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 63) == 0)
					calm_left = $urandom_range(30, 80);
				gap_left = (calm_left > 0) ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted word: predict its report
	always @(posedge clk) begin : take_events
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			owed_reports.push_back(apply_key_event(key_code, pressed));
			events_taken++;
			if (slot_fill > max_fill)
				max_fill = slot_fill;
		end
	end

	// receiver: random stalls, two long hold-offs to back the block up
	always @(negedge clk) begin : drive_ready
		static int stall_left = 0;
		static int calm_left = 0;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ((long_holds == 0 && reports_seen >= 300) ||
			(long_holds == 1 && reports_seen >= 900)) begin
			out_ready <= 1'b0;
			long_holds++;
			stall_left = 120;
		end else begin
			out_ready <= 1'b1;
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 63) == 0)
				calm_left = $urandom_range(30, 80);
			else
				stall_left = pick_gap();
		end
	end

	// field compare helper, unknown bits count as a mismatch
	task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$realtime, field, want, got);
		end
	endtask

	// monitor: compare each report word with the oldest prediction
	always @(posedge clk) begin : check_reports
		boot_report_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			if (owed_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report with none expected, expected none, actual slots_used %0d",
					$realtime, slots_used);
			end else begin
				want = owed_reports.pop_front();
				if (want.send)
					reports_changed++;
				check_field("send_report", want.send, send_report);
				check_field("modifier_byte", want.mods, modifier_byte);
				check_field("slot_0", want.slots[0], slot_0);
				check_field("slot_1", want.slots[1], slot_1);
				check_field("slot_2", want.slots[2], slot_2);
				check_field("slot_3", want.slots[3], slot_3);
				check_field("slot_4", want.slots[4], slot_4);
				check_field("slot_5", want.slots[5], slot_5);
				check_field("slots_used", want.used, slots_used);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still owed",
				cycles, owed_reports.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int n;
		held_map  = '0;
		mod_state = '0;
		foreach (slot_codes[i])
			slot_codes[i] = '0;
		slot_fill = 0;
		gen_held = '0;
		gen_held_count = 0;

		// directed: no key, modifiers at both ends, repeats and stray releases
		queue_key(8'h00, 1'b1);
		queue_key(8'h00, 1'b0);
		queue_key(8'he0, 1'b1);
		queue_key(8'he7, 1'b1);
		queue_key(8'he0, 1'b1);
		queue_key(8'he7, 1'b0);
		queue_key(8'h04, 1'b0);
		// fill all six slots, top code included
		queue_key(8'h04, 1'b1);
		queue_key(8'h05, 1'b1);
		queue_key(8'h06, 1'b1);
		queue_key(8'h07, 1'b1);
		queue_key(8'h08, 1'b1);
		queue_key(8'hff, 1'b1);
		// slots full: map bit set, report unchanged
		queue_key(8'h80, 1'b1);
		// middle release pulls the last slot down
		queue_key(8'h05, 1'b0);
		// key that never got a slot
		queue_key(8'h80, 1'b0);
		queue_key(8'hff, 1'b0);
		// another middle release, the last occupied slot moves down
		queue_key(8'h08, 1'b0);
		queue_key(8'h04, 1'b1);
		queue_key(8'he0, 1'b0);
		queue_key(8'h01, 1'b1);
		queue_key(8'h01, 1'b0);

		for (n = 0; n < RANDOM_EVENTS; n++)
			queue_random_event();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// everything offered and taken, then drain
		while (key_events.size() > 0 || in_valid)
			@(posedge clk);
		while (owed_reports.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (owed_reports.size() > 0) begin
			mismatches++;
			$display("%0t: %0d reports never arrived", $realtime, owed_reports.size());
		end

		$display("%0d key events, %0d reports (%0d with a change), %0d presses with slots full",
			events_taken, reports_seen, reports_changed, full_presses);
		$display("peak slot fill %0d, %0d long receiver hold-offs, %0d mismatches",
			max_fill, long_holds, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
